[rtl/pset_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pset_pkg
// Shared types and codes of the priority sorted entry table.
// ----------------------------------------------------------------------------
package pset_pkg;

  localparam int RANK_W  = 4;
  localparam int COUNT_W = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] prio;
    logic [31:0]        px;
    logic [31:0]        py;
    logic [31:0]        pz;
    logic [31:0]        pitch;
    logic [31:0]        yaw;
    logic [31:0]        roll;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    entry_t               entry;
    status_t              status;
    logic [COUNT_W-1:0]   count;
  } result_t;

endpackage

[rtl/pset_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pset_ram
// Simple dual-port entry memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pset_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 224
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/pset_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pset_ctrl
// Request sequencer: insertion walk from the top of the table, rank reads,
// entry count and result assembly.
// ----------------------------------------------------------------------------
module pset_ctrl
  import pset_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  op_t                         in_op,
  input  logic [RANK_W-1:0]           in_rank,
  input  entry_t                      in_entry,
  output logic                        res_valid,
  input  logic                        res_take,
  output result_t                     res,
  output logic                        wr_en,
  output logic [$clog2(CAPACITY)-1:0] wr_addr,
  output entry_t                      wr_data,
  output logic                        rd_en,
  output logic [$clog2(CAPACITY)-1:0] rd_addr,
  input  entry_t                      rd_data
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;
  localparam int XW   = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_PLACE = 5'b00100,
    S_FETCH = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [AW-1:0]   slot, slot_next;
  entry_t          ins, ins_next;
  entry_t          res_entry, res_entry_next;
  status_t         res_status, res_status_next;

  logic [CMPW-1:0] rank_x;
  logic [CMPW-1:0] count_c;
  logic [XW-1:0]   count_x;

  assign rank_x  = CMPW'(in_rank);
  assign count_c = CMPW'(count);
  assign count_x = XW'(count);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{entry: res_entry, status: res_status, count: count_x[COUNT_W-1:0]};

  always_comb begin
    state_next      = state;
    count_next      = count;
    slot_next       = slot;
    ins_next        = ins;
    res_entry_next  = res_entry;
    res_status_next = res_status;
    wr_en           = 1'b0;
    wr_addr         = slot;
    wr_data         = ins;
    rd_en           = 1'b0;
    rd_addr         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_entry_next  = '0;
          res_status_next = STATUS_OK;
          if (in_op == OP_INSERT) begin
            ins_next = in_entry;
            if (count == CW'(CAPACITY)) begin
              res_status_next = STATUS_FULL;
              state_next      = S_DONE;
            end else if (count == '0) begin
              wr_en      = 1'b1;
              wr_addr    = '0;
              wr_data    = in_entry;
              count_next = count + CW'(1);
              state_next = S_DONE;
            end else begin
              // start at the top entry and shift upward until the key fits
              rd_en      = 1'b1;
              rd_addr    = AW'(count - CW'(1));
              slot_next  = AW'(count);
              state_next = S_WALK;
            end
          end else begin
            if (rank_x >= count_c) begin
              res_status_next = STATUS_RANGE;
              state_next      = S_DONE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = rank_x[AW-1:0];
              state_next = S_FETCH;
            end
          end
        end
      end
      S_WALK: begin
        // rd_data holds the entry at slot-1
        wr_en = 1'b1;
        if ($signed(rd_data.prio) > $signed(ins.prio)) begin
          wr_data = rd_data;
          if (slot == AW'(1)) begin
            slot_next  = '0;
            state_next = S_PLACE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = slot - AW'(2);
            slot_next = slot - AW'(1);
          end
        end else begin
          count_next = count + CW'(1);
          state_next = S_DONE;
        end
      end
      S_PLACE: begin
        wr_en      = 1'b1;
        count_next = count + CW'(1);
        state_next = S_DONE;
      end
      S_FETCH: begin
        res_entry_next = rd_data;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot       <= slot_next;
    ins        <= ins_next;
    res_entry  <= res_entry_next;
    res_status <= res_status_next;
  end

  // table never holds more entries than it has slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // the walk reads below the slot it writes, so no same-entry overlap
  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (rd_addr < wr_addr))
    else $error("walk read does not trail write");

  // placing at the bottom slot completes the insert
  a_place_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_PLACE) |=> (state == S_DONE) && (count == $past(count) + CW'(1)))
    else $error("bottom placement did not complete insert");

  // memory is written only while an insert is in progress
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_IDLE || state == S_WALK || state == S_PLACE))
    else $error("memory write outside insert");

endmodule

[rtl/priority_sorted_entry_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_sorted_entry_table
// Table of entries kept in ascending signed priority order, stable on ties.
// ----------------------------------------------------------------------------
// Usage:
//   One request channel (in_valid/in_ready) carries an insert or a rank read,
//   one result channel (out_valid/out_ready) returns exactly one result per
//   request: the read entry (zero otherwise), the entry count after the
//   request and a status code (ok, table full, rank beyond count).
//   An insert walks down from the top entry, moving each larger entry up one
//   slot through the single-port-read entry memory, one entry per cycle.
//   The result of an insert waits for the walk past every entry with larger
//   priority. A read fetches its entry from memory first; an insert into an
//   empty table, a dropped insert or an out-of-range read needs no memory read.
//   One request is in work at a time; the next one is accepted in the cycle
//   after the previous result moves into the output register, even while
//   that result still waits there.
//   Reset empties the table at once (the count goes to zero; stored words
//   are not cleared). When the receiver stalls, the finished result holds in
//   the output register and the next request stops at its end state.
// ----------------------------------------------------------------------------
module priority_sorted_entry_table
  import pset_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      operation,
  input  logic [RANK_W-1:0]         read_rank,
  input  logic signed [31:0]        priority_req,
  input  logic [31:0]               point_x,
  input  logic [31:0]               point_y,
  input  logic [31:0]               point_z,
  input  logic [31:0]               dir_pitch,
  input  logic [31:0]               dir_yaw,
  input  logic [31:0]               dir_roll,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [31:0]               out_point_x,
  output logic [31:0]               out_point_y,
  output logic [31:0]               out_point_z,
  output logic [31:0]               out_pitch,
  output logic [31:0]               out_yaw,
  output logic [31:0]               out_roll,
  output logic signed [31:0]        out_priority,
  output logic [COUNT_W-1:0]        entry_count,
  output logic [1:0]                status
);

  localparam int AW = $clog2(CAPACITY);

  entry_t          in_entry;
  op_t             in_op;
  logic            res_valid;
  logic            res_take;
  result_t         res;
  result_t         out_res;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  entry_t          rd_data;

  assign in_op    = op_t'(operation);
  assign in_entry = '{prio: priority_req, px: point_x, py: point_y, pz: point_z,
                      pitch: dir_pitch, yaw: dir_yaw, roll: dir_roll};

  pset_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_rank   (read_rank),
    .in_entry  (in_entry),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  pset_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: takes the result when empty or being drained
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign out_point_x  = out_res.entry.px;
  assign out_point_y  = out_res.entry.py;
  assign out_point_z  = out_res.entry.pz;
  assign out_pitch    = out_res.entry.pitch;
  assign out_yaw      = out_res.entry.yaw;
  assign out_roll     = out_res.entry.roll;
  assign out_priority = out_res.entry.prio;
  assign entry_count  = out_res.count;
  assign status       = out_res.status;

endmodule

[tb/tb_priority_sorted_entry_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_sorted_entry_table
// Self-checking bench for the sorted entry table. A tracker keeps its own
// sorted copy of the table and predicts every result. A short directed run
// covers reads of an empty table, minimum, maximum and tied priorities, and
// reads at and past the count. A random run follows, which also fills the
// table and hits dropped inserts. Both handshake sides stall at random.
// ----------------------------------------------------------------------------

class entry_table_tracker #(int DEPTH = 16);
  pset_pkg::entry_t  slots[DEPTH];
  int unsigned       fill;
  pset_pkg::result_t pending_results[$];
  int unsigned       mismatch_count;

  function new();
    fill = 0;
    mismatch_count = 0;
  endfunction

  // predict the result of an accepted request and queue it
  function void note_request(pset_pkg::op_t op, logic [pset_pkg::RANK_W-1:0] rank,
                             pset_pkg::entry_t req);
    pset_pkg::result_t res;
    int unsigned pos;
    int unsigned i;
    res = '0;
    res.status = pset_pkg::STATUS_OK;
    if (op == pset_pkg::OP_INSERT) begin
      if (fill >= DEPTH) begin
        res.status = pset_pkg::STATUS_FULL;
      end else begin
        // new entry goes after every entry with priority <= its own
        pos = 0;
        while (pos < fill && $signed(slots[pos].prio) <= $signed(req.prio)) pos++;
        for (i = fill; i > pos; i--) slots[i] = slots[i - 1];
        slots[pos] = req;
        fill++;
      end
    end else if (rank >= fill) begin
      res.status = pset_pkg::STATUS_RANGE;
    end else begin
      res.entry = slots[rank];
    end
    res.count = fill[pset_pkg::COUNT_W-1:0];
    pending_results.push_back(res);
  endfunction

  function void report(string what, pset_pkg::result_t want, pset_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s", $time, what);
      $display("  expected prio %h pt %h %h %h dir %h %h %h count %0d status %0d",
               want.entry.prio, want.entry.px, want.entry.py, want.entry.pz,
               want.entry.pitch, want.entry.yaw, want.entry.roll, want.count,
               want.status);
      $display("  actual   prio %h pt %h %h %h dir %h %h %h count %0d status %0d",
               got.entry.prio, got.entry.px, got.entry.py, got.entry.pz,
               got.entry.pitch, got.entry.yaw, got.entry.roll, got.count,
               got.status);
    end
  endfunction

  function void check_result(pset_pkg::result_t got);
    pset_pkg::result_t want;
    string bad;
    bad = "";
    if (pending_results.size() == 0) begin
      want = '0;
      report("result with no request outstanding", want, got);
      return;
    end
    want = pending_results.pop_front();
    if (got.entry.prio !== want.entry.prio)   bad = {bad, " priority"};
    if (got.entry.px !== want.entry.px)       bad = {bad, " point_x"};
    if (got.entry.py !== want.entry.py)       bad = {bad, " point_y"};
    if (got.entry.pz !== want.entry.pz)       bad = {bad, " point_z"};
    if (got.entry.pitch !== want.entry.pitch) bad = {bad, " pitch"};
    if (got.entry.yaw !== want.entry.yaw)     bad = {bad, " yaw"};
    if (got.entry.roll !== want.entry.roll)   bad = {bad, " roll"};
    if (got.count !== want.count)             bad = {bad, " entry_count"};
    if (got.status !== want.status)           bad = {bad, " status"};
    if (bad != "") report({"wrong field:", bad}, want, got);
  endfunction
endclass

module tb_priority_sorted_entry_table;
  import pset_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = 1'b0;
  logic [RANK_W-1:0]  read_rank = '0;
  logic signed [31:0] priority_req = '0;
  logic [31:0]        point_x = '0;
  logic [31:0]        point_y = '0;
  logic [31:0]        point_z = '0;
  logic [31:0]        dir_pitch = '0;
  logic [31:0]        dir_yaw = '0;
  logic [31:0]        dir_roll = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [31:0]        out_point_x;
  logic [31:0]        out_point_y;
  logic [31:0]        out_point_z;
  logic [31:0]        out_pitch;
  logic [31:0]        out_yaw;
  logic [31:0]        out_roll;
  logic signed [31:0] out_priority;
  logic [COUNT_W-1:0] entry_count;
  logic [1:0]         status;

  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 82;

  entry_table_tracker #(TABLE_DEPTH) tracker;

  always #5 clk = ~clk;

  priority_sorted_entry_table #(
    .CAPACITY(TABLE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .read_rank(read_rank),
    .priority_req(priority_req),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .dir_pitch(dir_pitch),
    .dir_yaw(dir_yaw),
    .dir_roll(dir_roll),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_point_x(out_point_x),
    .out_point_y(out_point_y),
    .out_point_z(out_point_z),
    .out_pitch(out_pitch),
    .out_yaw(out_yaw),
    .out_roll(out_roll),
    .out_priority(out_priority),
    .entry_count(entry_count),
    .status(status)
  );

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic entry_t random_entry();
    entry_t e;
    e.px    = random_word();
    e.py    = random_word();
    e.pz    = random_word();
    e.pitch = random_word();
    e.yaw   = random_word();
    e.roll  = random_word();
    // a narrow band of small keys gives plenty of ties
    case ($urandom_range(0, 9))
      0:       e.prio = 32'sh8000_0000;
      1:       e.prio = 32'sh7fff_ffff;
      2, 3, 4: e.prio = int'($urandom_range(0, 6)) - 3;
      default: e.prio = $urandom;
    endcase
    return e;
  endfunction

  task automatic send_request(input op_t op, input logic [RANK_W-1:0] rank,
                              input entry_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    read_rank    <= rank;
    priority_req <= req.prio;
    point_x      <= req.px;
    point_y      <= req.py;
    point_z      <= req.pz;
    dir_pitch    <= req.pitch;
    dir_yaw      <= req.yaw;
    dir_roll     <= req.roll;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(op, rank, req);
  endtask

  // result side: check on accept, then pick ready for the next cycle
  always @(posedge clk) begin : result_side
    result_t got;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) begin
      got.entry.prio  = out_priority;
      got.entry.px    = out_point_x;
      got.entry.py    = out_point_y;
      got.entry.pz    = out_point_z;
      got.entry.pitch = out_pitch;
      got.entry.yaw   = out_yaw;
      got.entry.roll  = out_roll;
      got.count       = entry_count;
      got.status      = status_t'(status);
      tracker.check_result(got);
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("priority_sorted_entry_table: mismatch");
    $finish;
  end

  initial begin
    entry_t req;
    int unsigned n;
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table: both ends of the rank range are out of range
    send_request(OP_READ, 4'd0, random_entry());
    send_request(OP_READ, 4'd15, random_entry());

    req = '0;
    send_request(OP_INSERT, 4'd0, req);
    req = '1;
    req.prio = 32'sh7fff_ffff;
    send_request(OP_INSERT, 4'd15, req);
    req = random_entry();
    req.prio = 32'sh8000_0000;
    send_request(OP_INSERT, 4'd0, req);
    // ties with earlier zero and maximum keys must land after them
    req = random_entry();
    req.prio = 0;
    send_request(OP_INSERT, 4'd5, req);
    req = random_entry();
    req.prio = 32'sh7fff_ffff;
    send_request(OP_INSERT, 4'd10, req);
    req = random_entry();
    req.prio = -1;
    send_request(OP_INSERT, 4'd3, req);

    // every stored rank, then at and past the count
    for (n = 0; n < 9; n++) send_request(OP_READ, n[RANK_W-1:0], random_entry());
    send_request(OP_READ, 4'd15, random_entry());

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 29;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_request($urandom_range(0, 1) ? OP_READ : OP_INSERT,
                   RANK_W'($urandom_range(0, 15)), random_entry());
    end
    in_valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0)
      $display("priority_sorted_entry_table: match");
    else
      $display("priority_sorted_entry_table: mismatch");
    $finish;
  end

endmodule

[files.f]
rtl/pset_pkg.sv
rtl/pset_ram.sv
rtl/pset_ctrl.sv
rtl/priority_sorted_entry_table.sv
tb/tb_priority_sorted_entry_table.sv
